[rtl/ssc_pkg.sv]
package ssc_pkg;

  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_TYPE  = 4'd1,
    PH_TTL   = 4'd2,
    PH_EXP   = 4'd3,
    PH_KLEN  = 4'd4,
    PH_KEY   = 4'd5,
    PH_CNT   = 4'd6,
    PH_ELEN  = 4'd7,
    PH_ELEM  = 4'd8,
    PH_SCORE = 4'd9,
    PH_EOF   = 4'd10,
    PH_TRAIL = 4'd11,
    PH_SKIP  = 4'd12,
    PH_NONE  = 4'd13
  } phase_t;

  localparam logic [2:0] KIND_STRING = 3'd0;
  localparam logic [2:0] KIND_ZSET   = 3'd1;
  localparam logic [2:0] KIND_HASH   = 3'd3;
  localparam logic [2:0] KIND_MAX    = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_MAGIC      = 4'd2;
  localparam logic [3:0] ST_VERSION    = 4'd3;
  localparam logic [3:0] ST_CRC        = 4'd4;
  localparam logic [3:0] ST_COMPRESSED = 4'd5;
  localparam logic [3:0] ST_TYPE       = 4'd6;
  localparam logic [3:0] ST_TRUNC      = 4'd7;
  localparam logic [3:0] ST_EOF        = 4'd8;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] MIN_FILE = 32'd19;
  localparam logic [7:0]  EOF_BYTE = 8'hFF;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    magic_byte = 8'h4D;
      3'd1:    magic_byte = 8'h59;
      3'd2:    magic_byte = 8'h52;
      3'd3:    magic_byte = 8'h45;
      default: magic_byte = 8'h44;
    endcase
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/ssc_in_if.sv]
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last;
  modport source (output valid, output file_byte, output last, input ready);
  modport sink (input valid, input file_byte, input last, output ready);
endinterface

[rtl/ssc_out_if.sv]
interface ssc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [3:0]  byte_role;
  logic [2:0]  entry_kind;
  logic [31:0] entry_number;
  logic        entry_expired;
  logic        done_res;
  logic [3:0]  status;
  modport source (output valid, output byte_value, output byte_role, output entry_kind,
                  output entry_number, output entry_expired, output done_res,
                  output status, input ready);
  modport sink (input valid, input byte_value, input byte_role, input entry_kind,
                input entry_number, input entry_expired, input done_res,
                input status, output ready);
endinterface

[rtl/ssc_cfg_if.sv]
interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] load_time_ms;
  modport source (output valid, output load_time_ms, input ready);
  modport sink (input valid, input load_time_ms, output ready);
endinterface

[rtl/snapshot_stream_checker.sv]
// An input transfer's result is held in the output register from the cycle after the transfer.
// Throughput: one byte per cycle; the output register takes a new result whenever
// it is empty or its result is transferred in the same cycle.
// Reset (rst, synchronous): parser state returns to the start of a file,
// load_time_ms clears to 0. After each last byte the parser also restarts.
module snapshot_stream_checker (
  input  logic clk,
  input  logic rst,
  ssc_in_if.sink    in_ch,
  ssc_out_if.source out_ch,
  ssc_cfg_if.sink   cfg
);

  logic [63:0] load_time_ms;
  logic [7:0]  delay_bytes [4];
  logic [31:0] crc_reg;
  logic [31:0] bytes_seen;
  ssc_pkg::phase_t parse_phase;
  logic [2:0]  field_byte_count;
  logic [63:0] assembly_word;
  logic [31:0] string_bytes_left;
  logic [31:0] members_left;
  logic [31:0] entries_left;
  logic [31:0] current_entry;
  logic [2:0]  kind_reg;
  logic        ttl_flag;
  logic        expired;
  logic        second_string;
  logic [3:0]  first_error;
  logic        hdr_compressed;

  logic        out_valid;
  logic [7:0]  o_value;
  logic [3:0]  o_role;
  logic [2:0]  o_kind;
  logic [31:0] o_entry;
  logic        o_exp;
  logic        o_done;
  logic [3:0]  o_status;

  logic accept;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg.ready = 1'b1;

  ssc_pkg::phase_t phase_next;
  logic [31:0] crc_next;
  logic [2:0]  fbc_next;
  logic [63:0] asm_next;
  logic [31:0] sbl_next;
  logic [31:0] ml_next;
  logic [31:0] el_next;
  logic [31:0] ce_next;
  logic [2:0]  kind_next;
  logic        ttl_next;
  logic        exp_next;
  logic        ss_next;
  logic [3:0]  err_next;
  logic        hc_next;
  logic [31:0] seen_next;
  logic [7:0]  leaving;
  logic        real_byte;
  logic [3:0]  role;
  logic [2:0]  kind_out;
  logic        exp_out;
  logic [3:0]  status;
  logic [31:0] idx;
  logic [63:0] asm_or;
  logic [2:0]  need;
  logic        complete;
  logic        finish;
  logic [31:0] stored;

  always_comb begin
    leaving    = delay_bytes[0];
    real_byte  = bytes_seen >= 32'd4;
    idx        = bytes_seen - 32'd4;
    phase_next = parse_phase;
    crc_next   = crc_reg;
    fbc_next   = field_byte_count;
    asm_next   = assembly_word;
    sbl_next   = string_bytes_left;
    ml_next    = members_left;
    el_next    = entries_left;
    ce_next    = current_entry;
    kind_next  = kind_reg;
    ttl_next   = ttl_flag;
    exp_next   = expired;
    ss_next    = second_string;
    err_next   = first_error;
    hc_next    = hdr_compressed;
    finish     = 1'b0;
    role       = ssc_pkg::PH_NONE;
    kind_out   = ssc_pkg::KIND_NONE;
    exp_out    = 1'b0;
    status     = ssc_pkg::ST_OK;
    need = (parse_phase == ssc_pkg::PH_EXP || parse_phase == ssc_pkg::PH_SCORE) ?
           3'd7 : 3'd3;
    asm_or   = assembly_word | ({56'd0, leaving} << {field_byte_count, 3'b000});
    complete = field_byte_count >= need;

    if (real_byte) begin
      role     = parse_phase;
      crc_next = ssc_pkg::crc_byte(crc_reg, leaving);
      unique case (parse_phase)
        ssc_pkg::PH_HDR: begin
          if (idx < 32'd5) begin
            if (leaving != ssc_pkg::magic_byte(idx[2:0]) && err_next == ssc_pkg::ST_OK)
              err_next = ssc_pkg::ST_MAGIC;
          end else if (idx == 32'd9) begin
            hc_next = leaving[0];
            if (leaving[0] && err_next == ssc_pkg::ST_OK) err_next = ssc_pkg::ST_COMPRESSED;
          end else begin
            asm_next = asm_or;
            fbc_next = field_byte_count + 3'd1;
            if (complete) begin
              fbc_next = 3'd0;
              asm_next = 64'd0;
              if (idx < 32'd9) begin
                if (asm_or != 64'd3 && err_next == ssc_pkg::ST_OK)
                  err_next = ssc_pkg::ST_VERSION;
              end else begin
                el_next = asm_or[31:0];
                if (hdr_compressed) phase_next = ssc_pkg::PH_SKIP;
                else phase_next = (asm_or[31:0] != 32'd0) ? ssc_pkg::PH_TYPE :
                                  ssc_pkg::PH_EOF;
              end
            end
          end
        end
        ssc_pkg::PH_TYPE: begin
          if (leaving > {5'd0, ssc_pkg::KIND_MAX}) begin
            if (err_next == ssc_pkg::ST_OK) err_next = ssc_pkg::ST_TYPE;
            phase_next = ssc_pkg::PH_SKIP;
          end else begin
            kind_next  = leaving[2:0];
            ttl_next   = 1'b0;
            exp_next   = 1'b0;
            ss_next    = 1'b0;
            phase_next = ssc_pkg::PH_TTL;
          end
        end
        ssc_pkg::PH_TTL: begin
          if (leaving != 8'd0) begin
            ttl_next   = 1'b1;
            phase_next = ssc_pkg::PH_EXP;
          end else begin
            phase_next = ssc_pkg::PH_KLEN;
          end
        end
        ssc_pkg::PH_EXP, ssc_pkg::PH_SCORE: begin
          asm_next = asm_or;
          fbc_next = field_byte_count + 3'd1;
          if (complete) begin
            fbc_next   = 3'd0;
            asm_next   = 64'd0;
            phase_next = ssc_pkg::PH_KLEN;
            if (parse_phase == ssc_pkg::PH_SCORE) phase_next = ssc_pkg::PH_ELEN;
            else if (asm_or <= load_time_ms) exp_next = 1'b1;
          end
        end
        ssc_pkg::PH_KLEN, ssc_pkg::PH_ELEN, ssc_pkg::PH_CNT: begin
          asm_next = asm_or;
          fbc_next = field_byte_count + 3'd1;
          if (complete) begin
            fbc_next = 3'd0;
            asm_next = 64'd0;
            if (parse_phase == ssc_pkg::PH_CNT) begin
              ml_next = asm_or[31:0];
              if (asm_or[31:0] == 32'd0) finish = 1'b1;
              else if (kind_reg == ssc_pkg::KIND_ZSET) phase_next = ssc_pkg::PH_SCORE;
              else phase_next = ssc_pkg::PH_ELEN;
            end else begin
              sbl_next = asm_or[31:0];
              if (asm_or[31:0] != 32'd0) begin
                phase_next = (parse_phase == ssc_pkg::PH_KLEN) ? ssc_pkg::PH_KEY :
                             ssc_pkg::PH_ELEM;
              end else if (parse_phase == ssc_pkg::PH_KLEN) begin
                if (kind_reg == ssc_pkg::KIND_STRING) begin
                  ml_next = 32'd1;
                  phase_next = ssc_pkg::PH_ELEN;
                end else phase_next = ssc_pkg::PH_CNT;
              end else if (kind_reg == ssc_pkg::KIND_HASH && !second_string) begin
                ss_next = 1'b1;
                phase_next = ssc_pkg::PH_ELEN;
              end else begin
                ss_next = 1'b0;
                ml_next = members_left - 32'd1;
                if (ml_next == 32'd0) finish = 1'b1;
                else if (kind_reg == ssc_pkg::KIND_ZSET) phase_next = ssc_pkg::PH_SCORE;
                else phase_next = ssc_pkg::PH_ELEN;
              end
            end
          end
        end
        ssc_pkg::PH_KEY: begin
          sbl_next = string_bytes_left - 32'd1;
          if (sbl_next == 32'd0) begin
            if (kind_reg == ssc_pkg::KIND_STRING) begin
              ml_next = 32'd1;
              phase_next = ssc_pkg::PH_ELEN;
            end else phase_next = ssc_pkg::PH_CNT;
          end
        end
        ssc_pkg::PH_ELEM: begin
          sbl_next = string_bytes_left - 32'd1;
          if (sbl_next == 32'd0) begin
            if (kind_reg == ssc_pkg::KIND_HASH && !second_string) begin
              ss_next = 1'b1;
              phase_next = ssc_pkg::PH_ELEN;
            end else begin
              ss_next = 1'b0;
              ml_next = members_left - 32'd1;
              if (ml_next == 32'd0) finish = 1'b1;
              else if (kind_reg == ssc_pkg::KIND_ZSET) phase_next = ssc_pkg::PH_SCORE;
              else phase_next = ssc_pkg::PH_ELEN;
            end
          end
        end
        ssc_pkg::PH_EOF: begin
          if (leaving != ssc_pkg::EOF_BYTE) begin
            if (err_next == ssc_pkg::ST_OK) err_next = ssc_pkg::ST_EOF;
            phase_next = ssc_pkg::PH_SKIP;
          end else phase_next = ssc_pkg::PH_TRAIL;
        end
        default: begin
        end
      endcase
      kind_out = kind_next;
      exp_out  = exp_next;
      if (finish) begin
        ce_next    = current_entry + 32'd1;
        el_next    = entries_left - 32'd1;
        kind_next  = ssc_pkg::KIND_NONE;
        ttl_next   = 1'b0;
        exp_next   = 1'b0;
        ss_next    = 1'b0;
        phase_next = (el_next != 32'd0) ? ssc_pkg::PH_TYPE : ssc_pkg::PH_EOF;
      end
    end else begin
      leaving = 8'd0;
    end
    seen_next = (bytes_seen != 32'hFFFFFFFF) ? bytes_seen + 32'd1 : bytes_seen;
    stored = {in_ch.file_byte, delay_bytes[3], delay_bytes[2], delay_bytes[1]};
    if (in_ch.last) begin
      if (seen_next < ssc_pkg::MIN_FILE) status = ssc_pkg::ST_SHORT;
      else if (err_next == ssc_pkg::ST_MAGIC || err_next == ssc_pkg::ST_VERSION)
        status = err_next;
      else if (stored != ~crc_next) status = ssc_pkg::ST_CRC;
      else if (err_next != ssc_pkg::ST_OK) status = err_next;
      else if (phase_next >= ssc_pkg::PH_TYPE && phase_next <= ssc_pkg::PH_SCORE)
        status = ssc_pkg::ST_TRUNC;
      else if (phase_next == ssc_pkg::PH_EOF) status = ssc_pkg::ST_EOF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_time_ms <= 64'd0;
    end else if (cfg.valid) begin
      load_time_ms <= cfg.load_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last)) begin
      for (int i = 0; i < 4; i++) delay_bytes[i] <= 8'd0;
      crc_reg           <= 32'hFFFFFFFF;
      bytes_seen        <= 32'd0;
      parse_phase       <= ssc_pkg::PH_HDR;
      field_byte_count  <= 3'd0;
      assembly_word     <= 64'd0;
      string_bytes_left <= 32'd0;
      members_left      <= 32'd0;
      entries_left      <= 32'd0;
      current_entry     <= 32'd0;
      kind_reg          <= ssc_pkg::KIND_NONE;
      ttl_flag          <= 1'b0;
      expired           <= 1'b0;
      second_string     <= 1'b0;
      first_error       <= ssc_pkg::ST_OK;
      hdr_compressed    <= 1'b0;
    end else if (accept) begin
      delay_bytes[0]    <= delay_bytes[1];
      delay_bytes[1]    <= delay_bytes[2];
      delay_bytes[2]    <= delay_bytes[3];
      delay_bytes[3]    <= in_ch.file_byte;
      crc_reg           <= crc_next;
      bytes_seen        <= seen_next;
      parse_phase       <= phase_next;
      field_byte_count  <= fbc_next;
      assembly_word     <= asm_next;
      string_bytes_left <= sbl_next;
      members_left      <= ml_next;
      entries_left      <= el_next;
      current_entry     <= ce_next;
      kind_reg          <= kind_next;
      ttl_flag          <= ttl_next;
      expired           <= exp_next;
      second_string     <= ss_next;
      first_error       <= err_next;
      hdr_compressed    <= hc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_value  <= leaving;
      o_role   <= role;
      o_kind   <= kind_out;
      o_entry  <= current_entry;
      o_exp    <= exp_out;
      o_done   <= in_ch.last;
      o_status <= status;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.byte_value    = o_value;
  assign out_ch.byte_role     = o_role;
  assign out_ch.entry_kind    = o_kind;
  assign out_ch.entry_number  = o_entry;
  assign out_ch.entry_expired = o_exp;
  assign out_ch.done_res      = o_done;
  assign out_ch.status        = o_status;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(o_status))
    else $error("result dropped under stall");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last |=> bytes_seen == 32'd0 && parse_phase == ssc_pkg::PH_HDR)
    else $error("parser not restarted after last byte");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !o_done |-> o_status == ssc_pkg::ST_OK)
    else $error("status on non-final byte");
  a_none_early: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_seen < 32'd4 |=> o_role == ssc_pkg::PH_NONE)
    else $error("role given before delay filled");

endmodule
